@@ design/ged_pkg.sv @@
// Shared types and constants for the grid energy diffusion block.
// Used by ged_mem, ged_stencil and grid_energy_diffusion_step.
package ged_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int ENERGY_W      = 32;
    localparam int COORD_W       = 6;

    // floor(e / 5) == (e * RECIP5) >> RECIP5_SHIFT for every 32-bit e
    localparam logic [ENERGY_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int                  RECIP5_SHIFT = 34;
    localparam int                  SHARE_W      = 2 * ENERGY_W - RECIP5_SHIFT;

    // input word layout, lowest bit up
    localparam int IN_ROW_LO    = 0;
    localparam int IN_COL_LO    = IN_ROW_LO + COORD_W;
    localparam int IN_ENERGY_LO = IN_COL_LO + COORD_W;
    localparam int IN_SOLID_BIT = IN_ENERGY_LO + ENERGY_W;
    localparam int IN_DATA_W    = 48;

    // result word layout, lowest bit up
    localparam int OUT_SOLID_BIT = ENERGY_W;
    localparam int OUT_TOTAL_LO  = OUT_SOLID_BIT + 1;
    localparam int OUT_LOST_LO   = OUT_TOTAL_LO + ENERGY_W;
    localparam int OUT_USED_W    = OUT_LOST_LO + ENERGY_W;
    localparam int OUT_DATA_W    = 104;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_STEP  = 2'd2
    } func_t;

endpackage

@@ design/ged_mem.sv @@
// Cell storage: double-banked energy memory and a solid-flag memory.
// One read and one write port each, registered read data. Uses ged_pkg.
module ged_mem
    import ged_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int CELLS = GRID_SIDE * GRID_SIDE,
    localparam int IW = $clog2(CELLS),
    localparam int EW = $clog2(2 * CELLS)
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic                rd_bank,
    input  logic [IW-1:0]       rd_idx,
    input  logic                wr_en,
    input  logic                wr_bank,
    input  logic [IW-1:0]       wr_idx,
    input  logic [ENERGY_W-1:0] wr_energy,
    input  logic                wr_solid_en,
    input  logic                wr_solid,
    output logic [ENERGY_W-1:0] rd_energy,
    output logic                rd_solid
);

    logic [ENERGY_W-1:0] energy_mem [2*CELLS];
    logic                solid_mem  [CELLS];

    logic [EW-1:0] rd_addr;
    logic [EW-1:0] wr_addr;

    assign rd_addr = rd_bank ? EW'(rd_idx) + EW'(CELLS) : EW'(rd_idx);
    assign wr_addr = wr_bank ? EW'(wr_idx) + EW'(CELLS) : EW'(wr_idx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            energy_mem[wr_addr] <= wr_energy;
        end
        if (wr_en && wr_solid_en) begin
            solid_mem[wr_idx] <= wr_solid;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_energy <= energy_mem[rd_addr];
            rd_solid  <= solid_mem[rd_idx];
        end
    end

endmodule

@@ design/ged_stencil.sv @@
// Diffusion pass sequencer: gathers each cell's new energy from its own word,
// its four neighbors and the edge cells folded onto it. Uses ged_pkg.
module ged_stencil
    import ged_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int CELLS = GRID_SIDE * GRID_SIDE,
    localparam int IW = $clog2(CELLS),
    localparam int CW = $clog2(GRID_SIDE)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ENERGY_W-1:0] rd_energy,
    input  logic                rd_solid,
    output logic                rd_en,
    output logic [IW-1:0]       rd_idx,
    output logic                wr_en,
    output logic [IW-1:0]       wr_idx,
    output logic [ENERGY_W-1:0] wr_energy,
    output logic                done,
    output logic [ENERGY_W-1:0] total
);

    localparam logic [CW-1:0] CTR  = CW'(GRID_SIDE / 2);
    localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

    typedef enum logic [1:0] {K_SELF, K_NBR, K_EXTRA} kind_t;

    typedef struct packed {
        kind_t         kind;
        logic          folded;
        logic          last;
        logic          fin;
        logic [IW-1:0] idx;
    } tag_t;

    // slots: 0 self, 1 up, 2 down, 3 left, 4 right,
    // 5/6 top and bottom edge (center row), 7/8 left and right edge (center col)
    logic          busy_reg, busy_next;
    logic [CW-1:0] r_reg, r_next, c_reg, c_next;
    logic [3:0]    k_reg, k_next;

    logic [CW-1:0] tr, tc;
    kind_t         kind;
    logic          folded;
    logic          cell_last;
    tag_t          iss_tag;

    logic                  p1_vld_reg;
    tag_t                  p1_tag_reg;
    logic                  p2_vld_reg;
    tag_t                  p2_tag_reg;
    logic [ENERGY_W-1:0]   p2_e_reg;
    logic [2*ENERGY_W-1:0] p2_prod_reg;
    logic                  p2_solid_reg;

    logic [ENERGY_W-1:0] share, keep, add_a, add_b, acc_cur;
    logic [ENERGY_W-1:0] acc_reg;
    logic [ENERGY_W-1:0] self_share_reg;
    logic                self_solid_reg;
    logic                wr_en_reg;
    logic [IW-1:0]       wr_idx_reg;
    logic [ENERGY_W-1:0] wr_energy_reg;
    logic                done_reg;
    logic [ENERGY_W-1:0] total_reg;

    always_comb begin
        tr        = r_reg;
        tc        = c_reg;
        kind      = K_NBR;
        folded    = 1'b0;
        cell_last = 1'b0;
        k_next    = k_reg + 4'd1;
        case (k_reg)
            4'd0: begin
                kind = K_SELF;
            end
            4'd1: begin
                folded = (r_reg == '0);
                tr     = folded ? CTR : r_reg - CW'(1);
            end
            4'd2: begin
                folded = (r_reg == LAST);
                tr     = folded ? CTR : r_reg + CW'(1);
            end
            4'd3: begin
                folded = (c_reg == '0);
                tc     = folded ? CTR : c_reg - CW'(1);
            end
            4'd4: begin
                folded = (c_reg == LAST);
                tc     = folded ? CTR : c_reg + CW'(1);
                if (r_reg == CTR) begin
                    k_next = 4'd5;
                end else if (c_reg == CTR) begin
                    k_next = 4'd7;
                end else begin
                    cell_last = 1'b1;
                end
            end
            4'd5: begin
                kind = K_EXTRA;
                tr   = '0;
            end
            4'd6: begin
                kind = K_EXTRA;
                tr   = LAST;
                if (c_reg == CTR) begin
                    k_next = 4'd7;
                end else begin
                    cell_last = 1'b1;
                end
            end
            4'd7: begin
                kind = K_EXTRA;
                tc   = '0;
            end
            4'd8: begin
                kind      = K_EXTRA;
                tc        = LAST;
                cell_last = 1'b1;
            end
            default: begin
                cell_last = 1'b1;
            end
        endcase
        if (cell_last) begin
            k_next = '0;
        end
    end

    assign rd_idx = IW'(tr) * IW'(GRID_SIDE) + IW'(tc);
    assign rd_en  = busy_reg;

    always_comb begin
        iss_tag.kind   = kind;
        iss_tag.folded = folded;
        iss_tag.last   = cell_last;
        iss_tag.fin    = cell_last && (r_reg == LAST) && (c_reg == LAST);
        iss_tag.idx    = IW'(r_reg) * IW'(GRID_SIDE) + IW'(c_reg);
    end

    always_comb begin
        busy_next = busy_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            r_next    = '0;
            c_next    = '0;
        end else if (busy_reg && cell_last) begin
            if (iss_tag.fin) begin
                busy_next = 1'b0;
            end else if (c_reg == LAST) begin
                c_next = '0;
                r_next = r_reg + CW'(1);
            end else begin
                c_next = c_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            r_reg      <= '0;
            c_reg      <= '0;
            k_reg      <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            k_reg      <= busy_reg ? k_next : '0;
            p1_vld_reg <= busy_reg;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_tag_reg   <= iss_tag;
        p2_tag_reg   <= p1_tag_reg;
        p2_e_reg     <= rd_energy;
        p2_solid_reg <= rd_solid;
        p2_prod_reg  <= rd_energy * RECIP5;
    end

    assign share = ENERGY_W'(p2_prod_reg[2*ENERGY_W-1:RECIP5_SHIFT]);
    assign keep  = p2_e_reg - {share[ENERGY_W-3:0], 2'b00};

    always_comb begin
        // bounce: the share sent toward a solid target stays home
        add_a = (p2_tag_reg.kind == K_NBR && p2_solid_reg) ? self_share_reg : '0;
        add_b = '0;
        if (!self_solid_reg && ((p2_tag_reg.kind == K_NBR && !p2_tag_reg.folded)
                                || p2_tag_reg.kind == K_EXTRA)) begin
            add_b = share;
        end
        acc_cur = (p2_tag_reg.kind == K_SELF) ? keep : acc_reg + add_a + add_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_en_reg <= 1'b0;
            done_reg  <= 1'b0;
            total_reg <= '0;
        end else begin
            wr_en_reg <= p2_vld_reg && p2_tag_reg.last;
            done_reg  <= p2_vld_reg && p2_tag_reg.last && p2_tag_reg.fin;
            if (start && !busy_reg) begin
                total_reg <= '0;
            end else if (p2_vld_reg && p2_tag_reg.last) begin
                total_reg <= total_reg + acc_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_vld_reg) begin
            acc_reg <= acc_cur;
            if (p2_tag_reg.kind == K_SELF) begin
                self_share_reg <= share;
                self_solid_reg <= p2_solid_reg;
            end
        end
        wr_idx_reg    <= p2_tag_reg.idx;
        wr_energy_reg <= acc_cur;
    end

    assign wr_en     = wr_en_reg;
    assign wr_idx    = wr_idx_reg;
    assign wr_energy = wr_energy_reg;
    assign done      = done_reg;
    assign total     = total_reg;

endmodule

@@ design/grid_energy_diffusion_step.sv @@
// Top level of the grid energy diffusion block; instantiates ged_mem and
// ged_stencil, uses ged_pkg.
//
// Keeps a GRID_SIDE x GRID_SIDE grid of 32-bit energies and solid flags in
// on-chip memory. After reset a clearing pass zeroes the grid; no word is
// taken during it. Reads and steps wait while the result register is full.
// A step gathers every cell through the single memory read port: 5 reads
// per cell, 7 on the center row or column, 9 on the center cell, plus a
// drain of the read pipeline. Results come out of a register that holds
// one word; a new word is taken while it waits.
module grid_energy_diffusion_step
    import ged_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: row[5:0], col[11:6], energy_in[43:12], solid_in[44], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: energy_out[31:0], solid_out[32], total_energy[64:33],
    //          energy_lost[96:65], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int IW    = $clog2(CELLS);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_WR_RD, ST_WR_WB, ST_RD_RD, ST_RD_DATA, ST_STEP, ST_RESULT
    } state_t;

    state_t                state_reg;
    logic                  bank_reg;
    logic [IW-1:0]         clr_reg;
    logic [IW-1:0]         idx_reg;
    logic                  inside_reg;
    logic [ENERGY_W-1:0]   energy_reg;
    logic                  solid_reg;
    logic [ENERGY_W-1:0]   ref_reg;
    logic [ENERGY_W-1:0]   step_total_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic                accept;
    func_t               func;
    logic [COORD_W-1:0]  in_row, in_col;
    logic                in_inside;
    logic [IW-1:0]       in_idx;
    logic                out_free;
    logic                step_start;
    logic                load_out;
    logic [OUT_DATA_W-1:0] out_word;

    logic                mem_rd_en, mem_wr_en, mem_wr_bank, mem_wr_solid_en, mem_wr_solid;
    logic [IW-1:0]       mem_rd_idx, mem_wr_idx;
    logic [ENERGY_W-1:0] mem_wr_energy, mem_rd_energy;
    logic                mem_rd_solid;

    logic                stc_rd_en, stc_wr_en, stc_done;
    logic [IW-1:0]       stc_rd_idx, stc_wr_idx;
    logic [ENERGY_W-1:0] stc_wr_energy, stc_total;
    logic [ENERGY_W-1:0] new_ref;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign func      = func_t'(s_tuser);
    assign in_row    = s_tdata[IN_ROW_LO +: COORD_W];
    assign in_col    = s_tdata[IN_COL_LO +: COORD_W];
    assign in_inside = (32'(in_row) < GRID_SIDE) && (32'(in_col) < GRID_SIDE);
    assign in_idx    = IW'(32'(in_row) * GRID_SIDE + 32'(in_col));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign step_start = accept && (func == FUNC_STEP);
    assign new_ref   = ref_reg + energy_reg - mem_rd_energy;
    assign load_out  = out_free && (state_reg == ST_RD_DATA || state_reg == ST_RESULT);

    always_comb begin
        out_word = '0;
        if (state_reg == ST_RESULT) begin
            out_word[OUT_TOTAL_LO +: ENERGY_W] = step_total_reg;
            out_word[OUT_LOST_LO +: ENERGY_W]  = ref_reg - step_total_reg;
        end else if (inside_reg) begin
            out_word[ENERGY_W-1:0]  = mem_rd_energy;
            out_word[OUT_SOLID_BIT] = mem_rd_solid;
        end
    end

    always_comb begin
        mem_rd_en       = 1'b0;
        mem_rd_idx      = idx_reg;
        mem_wr_en       = 1'b0;
        mem_wr_bank     = bank_reg;
        mem_wr_idx      = idx_reg;
        mem_wr_energy   = energy_reg;
        mem_wr_solid_en = 1'b1;
        mem_wr_solid    = solid_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en     = 1'b1;
                mem_wr_idx    = clr_reg;
                mem_wr_energy = '0;
                mem_wr_solid  = 1'b0;
            end
            ST_WR_RD, ST_RD_RD: begin
                mem_rd_en = 1'b1;
            end
            ST_WR_WB: begin
                mem_wr_en = 1'b1;
            end
            ST_STEP: begin
                mem_rd_en       = stc_rd_en;
                mem_rd_idx      = stc_rd_idx;
                mem_wr_en       = stc_wr_en;
                mem_wr_bank     = !bank_reg;
                mem_wr_idx      = stc_wr_idx;
                mem_wr_energy   = stc_wr_energy;
                mem_wr_solid_en = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            bank_reg     <= 1'b0;
            clr_reg      <= '0;
            ref_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= out_word;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == IW'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (func)
                            FUNC_WRITE: state_reg <= in_inside ? ST_WR_RD : ST_IDLE;
                            FUNC_READ:  state_reg <= ST_RD_RD;
                            FUNC_STEP:  state_reg <= ST_STEP;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_WR_RD: begin
                    state_reg <= ST_WR_WB;
                end
                ST_WR_WB: begin
                    // track the loaded grid sum
                    ref_reg   <= new_ref;
                    state_reg <= ST_IDLE;
                end
                ST_RD_RD: begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_STEP: begin
                    if (stc_done) begin
                        bank_reg       <= !bank_reg;
                        step_total_reg <= stc_total;
                        state_reg      <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg    <= in_idx;
            inside_reg <= in_inside;
            energy_reg <= s_tdata[IN_ENERGY_LO +: ENERGY_W];
            solid_reg  <= s_tdata[IN_SOLID_BIT];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ged_mem #(
        .GRID_SIDE(GRID_SIDE)
    ) u_mem (
        .aclk        (aclk),
        .rd_en       (mem_rd_en),
        .rd_bank     (bank_reg),
        .rd_idx      (mem_rd_idx),
        .wr_en       (mem_wr_en),
        .wr_bank     (mem_wr_bank),
        .wr_idx      (mem_wr_idx),
        .wr_energy   (mem_wr_energy),
        .wr_solid_en (mem_wr_solid_en),
        .wr_solid    (mem_wr_solid),
        .rd_energy   (mem_rd_energy),
        .rd_solid    (mem_rd_solid)
    );

    ged_stencil #(
        .GRID_SIDE(GRID_SIDE)
    ) u_stencil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (step_start),
        .rd_energy (mem_rd_energy),
        .rd_solid  (mem_rd_solid),
        .rd_en     (stc_rd_en),
        .rd_idx    (stc_rd_idx),
        .wr_en     (stc_wr_en),
        .wr_idx    (stc_wr_idx),
        .wr_energy (stc_wr_energy),
        .done      (stc_done),
        .total     (stc_total)
    );

    a_stc_reads_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        stc_rd_en |-> (state_reg == ST_STEP))
        else $error("stencil reads outside a step");

    a_stc_writes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        stc_wr_en |-> (state_reg == ST_STEP))
        else $error("stencil writes outside a step");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        stc_done |=> (bank_reg != $past(bank_reg)))
        else $error("bank not swapped at end of step");

    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("word taken during clearing pass");

endmodule

@@ sim/ged_checker.sv @@
// Scoreboard for grid_energy_diffusion_step: watches both stream channels,
// keeps its own copy of the grid and predicts each result word. Uses ged_pkg.
`timescale 1ns / 1ps

module ged_checker
    import ged_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    words_pending
);

    localparam int SIDE  = GRID_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE;
    localparam int MID   = SIDE / 2;

    typedef struct packed {
        logic [31:0] energy;
        logic        solid;
        logic [31:0] total;
        logic [31:0] lost;
    } cell_result_t;

    logic [31:0]  heat [CELLS];
    logic [31:0]  heat_next [CELLS];
    logic         wall [CELLS];
    logic [31:0]  loaded_total;
    cell_result_t result_q[$];

    assign words_pending = result_q.size();

    function automatic int fold(input int c);
        return (c < 0 || c >= SIDE) ? MID : c;
    endfunction

    // Route one share to its target, or keep it when the target is a wall.
    task automatic push_share(input int self_idx, input int tr, input int tc,
                              input logic [31:0] share);
        int tgt;
        tgt = tr * SIDE + tc;
        if (wall[tgt]) heat_next[self_idx] += share;
        else           heat_next[tgt] += share;
    endtask

    task automatic diffuse_grid(output logic [31:0] sum);
        logic [31:0] e;
        logic [31:0] share;
        int          idx;
        for (int k = 0; k < CELLS; k++) heat_next[k] = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                idx   = r * SIDE + c;
                e     = heat[idx];
                share = e / 32'd5;
                push_share(idx, fold(r - 1), c, share);
                push_share(idx, fold(r + 1), c, share);
                push_share(idx, r, fold(c - 1), share);
                push_share(idx, r, fold(c + 1), share);
                heat_next[idx] += share + e % 32'd5;
            end
        end
        sum = '0;
        for (int k = 0; k < CELLS; k++) begin
            heat[k] = heat_next[k];
            sum += heat[k];
        end
    endtask

    task automatic predict_word(input logic [1:0] fn, input logic [IN_DATA_W-1:0] d);
        cell_result_t res;
        int           idx;
        logic [31:0]  sum;
        idx = int'(d[11:6]) + int'(d[5:0]) * SIDE;
        res = '0;
        case (fn)
            FUNC_WRITE: begin
                loaded_total += d[43:12] - heat[idx];
                heat[idx] = d[43:12];
                wall[idx] = d[44];
            end
            FUNC_READ: begin
                res.energy = heat[idx];
                res.solid  = wall[idx];
                result_q.push_back(res);
            end
            FUNC_STEP: begin
                diffuse_grid(sum);
                res.total = sum;
                res.lost  = loaded_total - sum;
                result_q.push_back(res);
            end
            default: ;  // unused code: drop
        endcase
    endtask

    task automatic check_word(input logic [OUT_DATA_W-1:0] d);
        cell_result_t want;
        if (result_q.size() == 0) begin
            $error("result word with nothing expected: %h", d);
            fail_count++;
            return;
        end
        want = result_q.pop_front();
        if (d[31:0] !== want.energy) begin
            $error("energy_out expected %h actual %h", want.energy, d[31:0]);
            fail_count++;
        end
        if (d[32] !== want.solid) begin
            $error("solid_out expected %b actual %b", want.solid, d[32]);
            fail_count++;
        end
        if (d[64:33] !== want.total) begin
            $error("total_energy expected %h actual %h", want.total, d[64:33]);
            fail_count++;
        end
        if (d[96:65] !== want.lost) begin
            $error("energy_lost expected %h actual %h", want.lost, d[96:65]);
            fail_count++;
        end
    endtask

    initial begin
        fail_count   = 0;
        loaded_total = '0;
        for (int k = 0; k < CELLS; k++) begin
            heat[k] = '0;
            wall[k] = 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_word(m_tdata);
            if (s_tvalid && s_tready) predict_word(s_tuser, s_tdata);
        end
    end

endmodule

@@ sim/tb_grid_energy_diffusion_step.sv @@
// Testbench top for grid_energy_diffusion_step: drives bursty stimulus,
// stalls the result side and reports the verdict. Needs ged_pkg and ged_checker.
`timescale 1ns / 1ps

module tb_grid_energy_diffusion_step
    import ged_pkg::*;
();

    // func code with no operation behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    words_pending;
    int                    burst_left;
    int                    stall_mode = 0;
    int                    stall_cnt = 0;

    always #5 aclk = ~aclk;

    grid_energy_diffusion_step u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    ged_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .words_pending(words_pending)
    );

    // Result side: switch between free flow, random stalls and long holds.
    always @(posedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_cnt  <= $urandom_range(8, 80);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_cell(input logic [1:0] fn, input logic [5:0] row,
                             input logic [5:0] col, input logic [31:0] e,
                             input logic sol);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, sol, e, col, row};
        do @(posedge aclk); while (!s_tready);
        // close the burst with a gap, or keep valid high for the next word
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 9);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 20);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int pick;
        int wait_cnt;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= FUNC_WRITE;
        burst_left  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, edges, center wall, max energies, unused code
        send_cell(FUNC_WRITE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0);
        send_cell(FUNC_WRITE, 6'd63, 6'd63, 32'd1000, 1'b0);
        send_cell(FUNC_WRITE, 6'd0,  6'd63, 32'd4, 1'b0);
        send_cell(FUNC_WRITE, 6'd63, 6'd0,  32'd12345, 1'b0);
        send_cell(FUNC_READ,  6'd0,  6'd0,  32'hFFFF_FFFF, 1'b1);
        send_cell(FUNC_READ,  6'd63, 6'd63, 32'd0, 1'b0);
        send_cell(FUNC_STEP,  6'd0,  6'd0,  32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd32, 6'd0,  32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd0,  6'd32, 32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd32, 6'd32, 32'd0, 1'b0);
        send_cell(FUNC_WRITE, 6'd32, 6'd32, 32'd777, 1'b1);
        send_cell(FUNC_WRITE, 6'd32, 6'd0,  32'd0, 1'b1);
        send_cell(FUNC_WRITE, 6'd1,  6'd1,  32'hFFFF_FFFF, 1'b0);
        send_cell(FUNC_WRITE, 6'd1,  6'd2,  32'd50, 1'b1);
        send_cell(FUNC_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_cell(FUNC_STEP,  6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_cell(FUNC_READ,  6'd32, 6'd32, 32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd1,  6'd2,  32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd0,  6'd0,  32'd0, 1'b0);
        send_cell(FUNC_WRITE, 6'd0,  6'd0,  32'd0, 1'b0);
        send_cell(FUNC_READ,  6'd0,  6'd0,  32'd0, 1'b0);

        // random: mostly writes and reads near the activity, few steps
        for (int n = 0; n < 120; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_cell(FUNC_WRITE,
                          6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom),
                          6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom),
                          rand_energy(), ($urandom_range(0, 3) == 0));
            else if (pick < 85)
                send_cell(FUNC_READ,
                          6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom),
                          6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom),
                          $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 93)
                send_cell(FUNC_STEP, 6'($urandom), 6'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            else
                send_cell(FUNC_UNUSED, 6'($urandom), 6'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (words_pending != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (50) @(posedge aclk);

        if (fail_count == 0 && words_pending == 0)
            $display("grid_energy_diffusion_step verification clean");
        else
            $display("grid_energy_diffusion_step verification failed");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("grid_energy_diffusion_step verification failed");
        $finish;
    end

endmodule
